// ----- rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(WORD_COUNT);
  localparam int NW_W       = WADDR_W + 1;

  localparam int BASE_W = 47;
  localparam int OFF_W  = 48;
  localparam int BB_W   = 32;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_SIZE = 2'd1;
  localparam logic [1:0] REG_BB   = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED   = 3'd2;
  localparam logic [2:0] ST_OUTSIDE     = 3'd3;
  localparam logic [2:0] ST_UNALIGNED   = 3'd4;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;
  localparam logic [2:0] ST_DUPLICATE   = 3'd6;
endpackage
`default_nettype wire

// ----- rtl/bitmap_block_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_action, in_offset
// out      output     out_valid/out_stall out_status, out_granted_offset, out_free_count,
//                                         out_total_count
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Steps: an allocate scans the bitmap one word at a time (registered RAM read, then
// find-first-free). Free and mark run the shared 48-step divider. Empty, exhausted or
// off-region requests skip the search and go straight to the result.
// A config write reruns the divider for the block count and clears
// the bitmap at once through per-word valid bits; reset needs no sweep.
// in_stall stays high while an item is in work; a result held by out_stall keeps the
// next item waiting in its final cycle.
module bitmap_block_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [47:0] in_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [47:0]      out_granted_offset,
  output logic [10:0]      out_free_count,
  output logic [10:0]      out_total_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [46:0] cfg_data
);
  localparam int IW = bba_pkg::IDX_W;
  localparam int CW = bba_pkg::CNT_W;
  localparam int BW = bba_pkg::BIT_W;
  localparam int AW = bba_pkg::WADDR_W;
  localparam int NW = bba_pkg::NW_W;
  localparam int WB = bba_pkg::WORD_BITS;
  localparam int PW = IW + bba_pkg::BB_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CSTART = 4'd1;
  localparam logic [3:0] S_CDIV   = 4'd2;
  localparam logic [3:0] S_LSTART = 4'd3;
  localparam logic [3:0] S_LDIV   = 4'd4;
  localparam logic [3:0] S_LRD    = 4'd5;
  localparam logic [3:0] S_LCHK   = 4'd6;
  localparam logic [3:0] S_SRD    = 4'd7;
  localparam logic [3:0] S_SCHK   = 4'd8;
  localparam logic [3:0] S_GMUL   = 4'd9;
  localparam logic [3:0] S_GADD   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [bba_pkg::BASE_W-1:0] base_r, size_r;
  logic [bba_pkg::BB_W-1:0]   bb_r;
  logic [CW-1:0]              bc_r, free_r;
  logic [IW-1:0]              hint_r, idx_r;
  logic [bba_pkg::WORD_COUNT-1:0] valid_r;
  logic [WB-1:0]              mem [bba_pkg::WORD_COUNT];
  logic [WB-1:0]              mem_q, word_q;
  logic [3:0]                 state_r;
  logic [1:0]                 act_r;
  logic [47:0]                rel_r, grant_r;
  logic [AW-1:0]              word_r;
  logic [NW-1:0]              step_r, nw;
  logic [PW-1:0]              prod_r;
  logic [2:0]                 st_r;

  logic                       div_start, div_done;
  logic [47:0]                div_dvd, quot;
  logic [31:0]                rem;

  logic                       wr_en;
  logic [WB-1:0]              wr_data;
  logic [WB-1:0]              lim_mask, pass_mask, cand, low_mask;
  logic [BW-1:0]              ffs;
  logic [47:0]                region_end;
  logic                       accept, cfg_wr, out_load;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = state_r != S_IDLE;
  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready &&
                      (cfg_index inside {bba_pkg::REG_BASE, bba_pkg::REG_SIZE, bba_pkg::REG_BB});
  assign out_load   = (state_r == S_FIN) && (!out_valid || !out_stall);
  assign region_end = {1'b0, base_r} + {1'b0, size_r};

  // Shared divider: block count on config, offset locate on free and mark.
  assign div_start = (state_r == S_CSTART && bb_r != '0) || (state_r == S_LSTART);
  assign div_dvd   = (state_r == S_CSTART) ? {1'b0, size_r} : rel_r;

  bba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (bb_r),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // Bitmap RAM; a word not written since the last clear reads as all free.
  always_ff @(posedge clk) begin
    mem_q <= mem[word_r];
    if (wr_en) mem[word_r] <= wr_data;
  end
  assign word_q = valid_r[word_r] ? mem_q : '0;

  // Search masks: blocks at or beyond the count read as used, the hint word is
  // split between the first and the wrap-around pass.
  always_comb begin
    nw       = bc_r[CW-1:BW] + NW'(|bc_r[BW-1:0]);
    low_mask = (WB'(1) << hint_r[BW-1:0]) - WB'(1);
    if ({1'b0, word_r} < bc_r[CW-1:BW]) lim_mask = '1;
    else if ({1'b0, word_r} == bc_r[CW-1:BW]) lim_mask = (WB'(1) << bc_r[BW-1:0]) - WB'(1);
    else lim_mask = '0;
    if (step_r == '0) pass_mask = ~low_mask;
    else if (step_r == nw) pass_mask = low_mask;
    else pass_mask = '1;
    cand = ~word_q & lim_mask & pass_mask;
    ffs  = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) ffs = BW'(b);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = word_q;
    if (state_r == S_LCHK) begin
      if (act_r == bba_pkg::ACT_FREE && word_q[idx_r[BW-1:0]]) begin
        wr_en = 1'b1;
        wr_data[idx_r[BW-1:0]] = 1'b0;
      end else if (act_r == bba_pkg::ACT_MARK && !word_q[idx_r[BW-1:0]]) begin
        wr_en = 1'b1;
        wr_data[idx_r[BW-1:0]] = 1'b1;
      end
    end else if (state_r == S_SCHK && |cand) begin
      wr_en = 1'b1;
      wr_data[ffs] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      base_r    <= '0;
      size_r    <= '0;
      bb_r      <= '0;
      bc_r      <= '0;
      free_r    <= '0;
      hint_r    <= '0;
      valid_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (wr_en) valid_r[word_r] <= 1'b1;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r   <= in_action;
            grant_r <= '0;
            st_r    <= bba_pkg::ST_OK;
            state_r <= S_FIN;
            case (in_action)
              bba_pkg::ACT_ALLOC: begin
                if (bc_r == '0) st_r <= bba_pkg::ST_EMPTY;
                else if (free_r == '0) st_r <= bba_pkg::ST_EXHAUSTED;
                else begin
                  word_r  <= hint_r[IW-1:BW];
                  step_r  <= '0;
                  state_r <= S_SRD;
                end
              end
              bba_pkg::ACT_FREE, bba_pkg::ACT_MARK: begin
                if (in_offset < {1'b0, base_r} || in_offset >= region_end)
                  st_r <= bba_pkg::ST_OUTSIDE;
                else if (bb_r == '0) st_r <= bba_pkg::ST_UNALIGNED;
                else begin
                  rel_r   <= in_offset - {1'b0, base_r};
                  state_r <= S_LSTART;
                end
              end
              default: begin
                st_r <= bba_pkg::ST_OK;
              end
            endcase
          end
        end
        S_CSTART: begin
          if (bb_r == '0) begin
            bc_r    <= '0;
            free_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            // saturate at the bitmap size
            if (quot >= 48'(bba_pkg::MAX_BLOCKS)) begin
              bc_r   <= CW'(bba_pkg::MAX_BLOCKS);
              free_r <= CW'(bba_pkg::MAX_BLOCKS);
            end else begin
              bc_r   <= quot[CW-1:0];
              free_r <= quot[CW-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        S_LSTART: state_r <= S_LDIV;
        S_LDIV: begin
          if (div_done) begin
            if (rem != '0) begin
              st_r    <= bba_pkg::ST_UNALIGNED;
              state_r <= S_FIN;
            end else if (quot >= {37'd0, bc_r}) begin
              st_r    <= bba_pkg::ST_OUTSIDE;
              state_r <= S_FIN;
            end else begin
              idx_r   <= quot[IW-1:0];
              word_r  <= quot[IW-1:BW];
              state_r <= S_LRD;
            end
          end
        end
        S_LRD: state_r <= S_LCHK;
        S_LCHK: begin
          if (act_r == bba_pkg::ACT_FREE) begin
            if (!word_q[idx_r[BW-1:0]]) st_r <= bba_pkg::ST_DOUBLE_FREE;
            else begin
              if (idx_r < hint_r) hint_r <= idx_r;
              free_r <= free_r + 1'b1;
            end
          end else begin
            if (word_q[idx_r[BW-1:0]]) st_r <= bba_pkg::ST_DUPLICATE;
            else if (free_r != '0) free_r <= free_r - 1'b1;
          end
          state_r <= S_FIN;
        end
        S_SRD: state_r <= S_SCHK;
        S_SCHK: begin
          if (|cand) begin
            idx_r <= {word_r, ffs};
            if ({1'b0, word_r, ffs} + CW'(1) == bc_r) hint_r <= '0;
            else hint_r <= {word_r, ffs} + IW'(1);
            free_r  <= free_r - 1'b1;
            state_r <= S_GMUL;
          end else if (step_r == nw) begin
            st_r    <= bba_pkg::ST_EXHAUSTED;
            state_r <= S_FIN;
          end else begin
            step_r  <= step_r + 1'b1;
            // advance with wrap at the last used word
            if ({1'b0, word_r} + NW'(1) == nw) word_r <= '0;
            else word_r <= word_r + 1'b1;
            state_r <= S_SRD;
          end
        end
        S_GMUL: begin
          prod_r  <= PW'(idx_r) * PW'(bb_r);
          state_r <= S_GADD;
        end
        S_GADD: begin
          grant_r <= {1'b0, base_r} + 48'(prod_r);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_valid          <= 1'b1;
            out_status         <= st_r;
            out_granted_offset <= grant_r;
            out_free_count     <= free_r;
            out_total_count    <= bc_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Config write: drop the bitmap and rerun the block count.
      if (cfg_wr) begin
        case (cfg_index)
          bba_pkg::REG_BASE: base_r <= cfg_data;
          bba_pkg::REG_SIZE: size_r <= cfg_data;
          bba_pkg::REG_BB:   bb_r   <= cfg_data[bba_pkg::BB_W-1:0];
          default:           bb_r   <= bb_r;
        endcase
        valid_r <= '0;
        hint_r  <= '0;
        state_r <= S_CSTART;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bba_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module bba_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [bba_pkg::OFF_W-1:0] dividend,
  input  wire logic [bba_pkg::BB_W-1:0]  divisor,
  output logic                           done,
  output logic      [bba_pkg::OFF_W-1:0] quotient,
  output logic      [bba_pkg::BB_W-1:0]  remainder
);
  localparam int CW = $clog2(bba_pkg::OFF_W + 1);

  logic [bba_pkg::OFF_W-1:0] dvd_r, dvd_nxt;
  logic [bba_pkg::BB_W-1:0]  rem_r, rem_nxt;
  logic [bba_pkg::BB_W-1:0]  div_r;
  logic [CW-1:0]             cnt_r;
  logic                      done_r;
  logic [bba_pkg::BB_W:0]    trial;
  logic                      ge;

  always_comb begin
    trial   = {rem_r, dvd_r[bba_pkg::OFF_W-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? (trial[bba_pkg::BB_W-1:0] - div_r) : trial[bba_pkg::BB_W-1:0];
    dvd_nxt = {dvd_r[bba_pkg::OFF_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(bba_pkg::OFF_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire
